FILE: sv/cdbc_pkg.sv
// Shared constants and types for the color delta bit-length coder.
`default_nettype none
package cdbc_pkg;

    localparam int NUM_CH   = 4;
    localparam int CHAN_W   = 8;
    localparam int KEPT_W   = 4;
    localparam int LEN_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [KEPT_W-1:0] KEPT_RESET = KEPT_W'(CHAN_W);

    localparam logic [CFG_IDX_W-1:0] REG_LUMA_BITS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_DIFF_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_DIFF_BITS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_BITS     = 2'd3;

    typedef struct packed {
        logic advance;
        logic restart;
    } chan_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/color_delta_bitlength_coder.sv
// Top level of the color delta bit-length coder with input and result registers.
// A result reaches m_tdata after passing the input register and then the result register.
// One pixel per cycle unless m_tready stalls; each passes one register stage to the next.
// The input register is refilled in the same cycle that its pixel moves to the result register.
// Reset (aresetn low, synchronous) empties both stages, clears the stored levels to zero
// and sets every kept-bits register to eight.
`default_nettype none
module color_delta_bitlength_coder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,  // red, green, blue, alpha
    input  wire logic                              s_tuser,  // restart
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // len_c0, bits_c0, len_c1, bits_c1, len_c2, bits_c2, len_c3, bits_c3
    output logic      [47:0]                       m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [cdbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cdbc_pkg::KEPT_W-1:0]       cfg_wdata
);

    logic [cdbc_pkg::KEPT_W-1:0] kept_reg [cdbc_pkg::NUM_CH];
    logic [cdbc_pkg::KEPT_W-1:0] kept_next [cdbc_pkg::NUM_CH];

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] in_data_reg;
    logic        in_restart_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [47:0] out_data_reg;
    logic        advance;

    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [cdbc_pkg::CHAN_W-1:0] chan_value [cdbc_pkg::NUM_CH];
    logic [cdbc_pkg::LEN_W-1:0]  len [cdbc_pkg::NUM_CH];
    logic [cdbc_pkg::CHAN_W-1:0] payload [cdbc_pkg::NUM_CH];
    logic [47:0]                 result;
    cdbc_pkg::chan_ctrl_t        ctrl;

    always_comb begin
        for (int k = 0; k < cdbc_pkg::NUM_CH; k++) begin
            kept_next[k] = kept_reg[k];
        end
        if (cfg_wr_en) begin
            unique case (cfg_index)
                cdbc_pkg::REG_LUMA_BITS:      kept_next[0] = cfg_wdata;
                cdbc_pkg::REG_BLUE_DIFF_BITS: kept_next[1] = cfg_wdata;
                cdbc_pkg::REG_RED_DIFF_BITS:  kept_next[2] = cfg_wdata;
                cdbc_pkg::REG_ALPHA_BITS:     kept_next[3] = cfg_wdata;
                default:                      kept_next[0] = kept_reg[0];
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Reversible color transform, each channel wrapping to eight bits.
    always_comb begin
        red   = in_data_reg[7:0];
        green = in_data_reg[15:8];
        blue  = in_data_reg[23:16];
        alpha = in_data_reg[31:24];
        chan_value[0] = green;
        chan_value[1] = blue - green;
        chan_value[2] = red - green;
        chan_value[3] = alpha;
        ctrl.advance = advance;
        ctrl.restart = in_restart_reg;
    end

    for (genvar k = 0; k < cdbc_pkg::NUM_CH; k++) begin : g_chan
        cdbc_chan u_chan (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .chan_value (chan_value[k]),
            .kept_bits  (kept_reg[k]),
            .len        (len[k]),
            .payload    (payload[k])
        );
        assign result[k*12 +: 12] = {payload[k], len[k]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < cdbc_pkg::NUM_CH; k++) begin
                kept_reg[k] <= cdbc_pkg::KEPT_RESET;
            end
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < cdbc_pkg::NUM_CH; k++) begin
                kept_reg[k] <= kept_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule
`default_nettype wire

FILE: sv/cdbc_chan.sv
// One channel: quantization, difference against the stored level, zigzag and bit length.
`default_nettype none
module cdbc_chan (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire cdbc_pkg::chan_ctrl_t         ctrl,
    input  wire logic [cdbc_pkg::CHAN_W-1:0]  chan_value,
    input  wire logic [cdbc_pkg::KEPT_W-1:0]  kept_bits,
    output logic      [cdbc_pkg::LEN_W-1:0]   len,
    output logic      [cdbc_pkg::CHAN_W-1:0]  payload
);

    logic [cdbc_pkg::CHAN_W-1:0] prev_level_reg;
    logic [cdbc_pkg::CHAN_W-1:0] prev_level_next;
    logic [cdbc_pkg::KEPT_W-1:0] kept_sat;
    logic [cdbc_pkg::KEPT_W-1:0] shift;
    logic [cdbc_pkg::CHAN_W-1:0] level;
    logic [cdbc_pkg::CHAN_W-1:0] prev;
    logic [cdbc_pkg::CHAN_W-1:0] mag;
    logic [cdbc_pkg::CHAN_W:0]   zz;
    logic [cdbc_pkg::CHAN_W:0]   val;
    logic [cdbc_pkg::CHAN_W:0]   top_bit;

    always_comb begin
        kept_sat = (kept_bits > cdbc_pkg::KEPT_RESET) ? cdbc_pkg::KEPT_RESET : kept_bits;
        shift    = cdbc_pkg::KEPT_RESET - kept_sat;
        level    = chan_value >> shift;
        prev     = ctrl.restart ? '0 : prev_level_reg;

        // Positive differences map to odd codes, the rest to even codes.
        if (level > prev) begin
            mag = level - prev;
            zz  = {mag, 1'b0} - 9'd1;
        end else begin
            mag = prev - level;
            zz  = {mag, 1'b0};
        end
        val = zz + 9'd1;

        len = '0;
        for (int i = 0; i <= cdbc_pkg::CHAN_W; i++) begin
            if (val[i]) begin
                len = cdbc_pkg::LEN_W'(i);
            end
        end

        // The payload is the value with its leading one removed.
        top_bit = 9'd1 << len;
        payload = cdbc_pkg::CHAN_W'(val ^ top_bit);

        prev_level_next = ctrl.advance ? level : prev_level_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= '0;
        end else begin
            prev_level_reg <= prev_level_next;
        end
    end

endmodule
`default_nettype wire
